/* rtl/twa_pkg.sv */
package twa_pkg;

	localparam int VALUE_WIDTH  = 32;
	localparam int LANES        = 6;
	localparam int IDX_W        = 3;
	localparam int ALPHA_BITS   = 16;
	localparam int ALPHA_W      = ALPHA_BITS + 1;
	localparam int THRUST_LIMIT = 40;
	localparam int CFG_IDX_W    = 3;

	// request codes
	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_WRENCH = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THRUST_CEIL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRUST_FLOOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA        = 3'd3;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_BITS);

	typedef struct packed {
		logic [1:0]                    req_type;
		logic [2:0]                    coef_row;
		logic [2:0]                    coef_col;
		logic signed [VALUE_WIDTH-1:0] coef_value;
		logic signed [VALUE_WIDTH-1:0] force_x;
		logic signed [VALUE_WIDTH-1:0] force_y;
		logic signed [VALUE_WIDTH-1:0] force_z;
		logic signed [VALUE_WIDTH-1:0] torque_x;
		logic signed [VALUE_WIDTH-1:0] torque_y;
		logic signed [VALUE_WIDTH-1:0] torque_z;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] thrust_one;
		logic signed [VALUE_WIDTH-1:0] thrust_two;
		logic signed [VALUE_WIDTH-1:0] thrust_three;
		logic signed [VALUE_WIDTH-1:0] thrust_four;
		logic signed [VALUE_WIDTH-1:0] thrust_five;
		logic signed [VALUE_WIDTH-1:0] thrust_six;
	} rsp_t;

	// wrench word travelling down the cell chain
	typedef struct packed {
		logic                          vld;
		logic [IDX_W-1:0]              idx;
		logic signed [VALUE_WIDTH-1:0] word;
	} lane_tag_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic                          load_en;
		logic [IDX_W-1:0]              load_col;
		logic signed [VALUE_WIDTH-1:0] load_value;
		logic                          tick_diff;
		logic                          tick_mul;
		logic                          tick_upd;
		logic [ALPHA_W-1:0]            alpha;
	} lane_ctl_t;

	// shaping limits shared by all cells
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] thrust_ceil;
		logic signed [VALUE_WIDTH-1:0] thrust_floor;
		logic [VALUE_WIDTH-2:0]        deadzone;
	} shape_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FEED,
		ST_DRAIN,
		ST_DIFF,
		ST_MUL,
		ST_UPD,
		ST_PUT
	} seq_state_t;

endpackage

/* rtl/twa_cell.sv */
module twa_cell #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  twa_pkg::lane_ctl_t                ctl,
	input  twa_pkg::shape_cfg_t               shp,
	input  twa_pkg::lane_tag_t                tag_in,
	output twa_pkg::lane_tag_t                tag_out,
	output logic signed [twa_pkg::VALUE_WIDTH-1:0] filt
);
	import twa_pkg::*;

	localparam int VW = VALUE_WIDTH;
	localparam int PW = 2 * VW;
	localparam int AW = PW + 3;
	localparam int TW = VW + 1 + ALPHA_W + 1;
	localparam logic signed [VW-1:0] SMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] SMIN = {1'b1, {(VW-1){1'b0}}};

	logic signed [VW-1:0] coef_q [LANES];
	lane_tag_t            hop_s1;
	logic signed [PW-1:0] prod_s2;
	logic [IDX_W-1:0]     pidx_s2;
	logic                 pvld_s2;
	logic signed [AW-1:0] acc_q;
	logic signed [VW-1:0] sat_q;
	logic                 sat_vld_q;
	logic signed [VW-1:0] target_q;
	logic signed [VW-1:0] filt_q;
	logic signed [VW:0]   diff_q;
	logic signed [TW-1:0] tprod_q;

	logic signed [AW-1:0] acc_nx;
	logic signed [AW-1:0] acc_sh;
	logic                 acc_fits;
	logic signed [VW-1:0] sat_nx;
	logic [VW-1:0]        mag;
	logic signed [VW-1:0] clip_hi;
	logic signed [VW-1:0] shaped;
	logic signed [TW-1:0] tstep;

	// accumulate, then floor shift and saturate on the last column
	always_comb begin
		if (pidx_s2 == '0) begin
			acc_nx = AW'(prod_s2);
		end else begin
			acc_nx = acc_q + AW'(prod_s2);
		end
		acc_sh   = acc_nx >>> FRAC_BITS;
		acc_fits = (&acc_sh[AW-1:VW-1]) | ~(|acc_sh[AW-1:VW-1]);
		if (acc_fits) begin
			sat_nx = acc_sh[VW-1:0];
		end else if (acc_sh[AW-1]) begin
			sat_nx = SMIN;
		end else begin
			sat_nx = SMAX;
		end
	end

	// deadzone on unsigned magnitude, then clamp to the ceiling and raise to the floor
	always_comb begin
		mag     = sat_q[VW-1] ? VW'(-sat_q) : VW'(sat_q);
		clip_hi = (shp.thrust_ceil < sat_q) ? shp.thrust_ceil : sat_q;
		if (mag < {1'b0, shp.deadzone}) begin
			shaped = '0;
		end else if (clip_hi < shp.thrust_floor) begin
			shaped = shp.thrust_floor;
		end else begin
			shaped = clip_hi;
		end
	end

	assign tstep = tprod_q >>> ALPHA_BITS;

	// hand the wrench beat on and track pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_s1    <= '0;
			pvld_s2   <= 1'b0;
			sat_vld_q <= 1'b0;
		end else begin
			hop_s1    <= tag_in;
			pvld_s2   <= hop_s1.vld;
			sat_vld_q <= pvld_s2 && (pidx_s2 == IDX_W'(LANES - 1));
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_s2     <= PW'(coef_q[hop_s1.idx]) * PW'(hop_s1.word);
		pidx_s2     <= hop_s1.idx;
		if (pvld_s2) begin
			acc_q <= acc_nx;
		end
		sat_q <= sat_nx;
		if (ctl.tick_diff) begin
			diff_q <= (VW+1)'(target_q) - (VW+1)'(filt_q);
		end
		if (ctl.tick_mul) begin
			tprod_q <= TW'(diff_q) * TW'($signed({1'b0, ctl.alpha}));
		end
	end

	// coefficient row, target and filtered command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < LANES; c++) begin
				coef_q[c] <= '0;
			end
			target_q <= '0;
			filt_q   <= '0;
		end else begin
			if (ctl.load_en) begin
				coef_q[ctl.load_col] <= ctl.load_value;
			end
			if (sat_vld_q) begin
				target_q <= shaped;
			end
			if (ctl.tick_upd) begin
				filt_q <= filt_q + tstep[VW-1:0];
			end
		end
	end

	assign tag_out = hop_s1;
	assign filt    = filt_q;

endmodule

/* rtl/thruster_wrench_allocator.sv */
// Channel  Dir  Handshake              Beat
// req      in   req_valid/req_ready    twa_pkg::req_t (load, wrench or tick)
// rsp      out  rsp_valid/rsp_ready    twa_pkg::rsp_t (six filtered commands)
// cfg      in   cfg_we                 cfg_index, cfg_wdata
//
// A load writes a coefficient and leaves the block idle. A wrench feeds, then
// drains: the six words walk down the row of six MAC cells one hop a cycle.
// A tick runs each cell filter multiplier through diff, multiply and update,
// then waits for the output register to free up. One item at a time.
// Reset clears the coefficient rows, targets and filtered commands and
// restores the default limits.
// A held output beat does not block loads or wrenches; it holds only a tick.
module thruster_wrench_allocator #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  twa_pkg::req_t                      req_data,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output twa_pkg::rsp_t                      rsp_data,
	input  logic                               cfg_we,
	input  logic [twa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [twa_pkg::VALUE_WIDTH-1:0]    cfg_wdata
);
	import twa_pkg::*;

	localparam int VW           = VALUE_WIDTH;
	localparam int DRAIN_CYCLES = LANES + 6;
	localparam int CNT_W        = $clog2(DRAIN_CYCLES + 1);
	localparam logic signed [VW-1:0] LIMIT_RST = VW'(THRUST_LIMIT) << FRAC_BITS;

	seq_state_t           state_q, state_nx;
	logic [CNT_W-1:0]     cnt_q, cnt_nx;
	logic signed [VW-1:0] wrench_q [LANES];
	shape_cfg_t           shp_q;
	logic [ALPHA_W-1:0]   alpha_q;
	logic [ALPHA_W-1:0]   alpha_eff;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;
	logic                 accept;
	logic                 load_go;
	logic                 put_go;
	lane_ctl_t            ctl [LANES];
	lane_tag_t            chain [LANES+1];
	logic signed [VW-1:0] filt [LANES];

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign load_go   = accept && (req_data.req_type == REQ_LOAD)
		&& (req_data.coef_row < 3'(LANES)) && (req_data.coef_col < 3'(LANES));
	assign put_go    = (state_q == ST_PUT) && (!rsp_valid_q || rsp_ready);
	assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			cnt_q   <= cnt_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		cnt_nx   = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				cnt_nx = '0;
				if (accept) begin
					case (req_data.req_type)
						REQ_WRENCH: state_nx = ST_FEED;
						REQ_TICK:   state_nx = ST_DIFF;
						default:    state_nx = ST_IDLE;
					endcase
				end
			end
			ST_FEED: begin
				if (cnt_q == CNT_W'(LANES - 1)) begin
					cnt_nx   = '0;
					state_nx = ST_DRAIN;
				end else begin
					cnt_nx = cnt_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (cnt_q == CNT_W'(DRAIN_CYCLES - 1)) begin
					cnt_nx   = '0;
					state_nx = ST_IDLE;
				end else begin
					cnt_nx = cnt_q + 1'b1;
				end
			end
			ST_DIFF: state_nx = ST_MUL;
			ST_MUL:  state_nx = ST_UPD;
			ST_UPD:  state_nx = ST_PUT;
			ST_PUT: begin
				if (put_go) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// latch the wrench beat
	always_ff @(posedge clk) begin
		if (accept && (req_data.req_type == REQ_WRENCH)) begin
			wrench_q[0] <= req_data.force_x;
			wrench_q[1] <= req_data.force_y;
			wrench_q[2] <= req_data.force_z;
			wrench_q[3] <= req_data.torque_x;
			wrench_q[4] <= req_data.torque_y;
			wrench_q[5] <= req_data.torque_z;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shp_q.thrust_ceil  <= LIMIT_RST;
			shp_q.thrust_floor <= -LIMIT_RST;
			shp_q.deadzone     <= '0;
			alpha_q            <= ALPHA_ONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRUST_CEIL:  shp_q.thrust_ceil  <= cfg_wdata;
				CFG_THRUST_FLOOR: shp_q.thrust_floor <= cfg_wdata;
				CFG_DEADZONE:     shp_q.deadzone     <= cfg_wdata[VW-2:0];
				CFG_ALPHA:        alpha_q            <= cfg_wdata[ALPHA_W-1:0];
				default:          ;
			endcase
		end
	end

	// feed one wrench word a cycle into the head of the chain
	always_comb begin
		chain[0].vld  = (state_q == ST_FEED);
		chain[0].idx  = cnt_q[IDX_W-1:0];
		chain[0].word = wrench_q[cnt_q[IDX_W-1:0]];
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		always_comb begin
			ctl[i].load_en    = load_go && (req_data.coef_row == IDX_W'(i));
			ctl[i].load_col   = req_data.coef_col;
			ctl[i].load_value = req_data.coef_value;
			ctl[i].tick_diff  = (state_q == ST_DIFF);
			ctl[i].tick_mul   = (state_q == ST_MUL);
			ctl[i].tick_upd   = (state_q == ST_UPD);
			ctl[i].alpha      = alpha_eff;
		end

		twa_cell #(
			.FRAC_BITS (FRAC_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl[i]),
			.shp     (shp_q),
			.tag_in  (chain[i]),
			.tag_out (chain[i+1]),
			.filt    (filt[i])
		);
	end

	// output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (put_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (put_go) begin
			rsp_q.thrust_one   <= filt[0];
			rsp_q.thrust_two   <= filt[1];
			rsp_q.thrust_three <= filt[2];
			rsp_q.thrust_four  <= filt[3];
			rsp_q.thrust_five  <= filt[4];
			rsp_q.thrust_six   <= filt[5];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

/* rtl/twa_checker.sv */
module twa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input twa_pkg::req_t req_data,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input twa_pkg::rsp_t rsp_data
);
	import twa_pkg::*;

	// a stalled output beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("output beat dropped or changed while stalled");

	// a coefficient load leaves the block ready for the next beat
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_data.req_type == REQ_LOAD) |=> req_ready)
		else $error("load did not complete in one cycle");

	// a wrench or tick keeps the block busy the next cycle
	a_work_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready
		&& ((req_data.req_type == REQ_WRENCH) || (req_data.req_type == REQ_TICK))
		|=> !req_ready)
		else $error("block ready right after a wrench or tick");

endmodule

bind thruster_wrench_allocator twa_checker u_twa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req_data  (req_data),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_data  (rsp_data)
);
